// ===== hdl/dlbr_pkg.sv =====
// ----------------------------------------------------------------------------
// dlbr_pkg
// Shared constants, payload types and the control interface of the
// fully connected layer with bias and ReLU.
// ----------------------------------------------------------------------------
package dlbr_pkg;

    localparam int MAX_INPUTS  = 256;
    localparam int MAX_OUTPUTS = 64;
    localparam int W_DEPTH     = MAX_INPUTS * MAX_OUTPUTS;

    localparam int IN_AW  = $clog2(MAX_INPUTS);
    localparam int OUT_AW = $clog2(MAX_OUTPUTS);
    localparam int W_AW   = $clog2(W_DEPTH);

    localparam int IN_SIZE_W  = 9;
    localparam int OUT_SIZE_W = 7;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    localparam int DATA_W = 16;
    localparam int FRAC_W = 8;
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + IN_AW + 2;

    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_BIAS   = 2'd1;
    localparam logic [1:0] CMD_ACT    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELU_ON  = 2'd2;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [13:0]              index;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [5:0]               column;
        logic signed [DATA_W-1:0] result_value;
        logic                     last;
    } t_out_item;

    typedef struct packed {
        logic [IN_AW-1:0]      in_last;
        logic [OUT_AW-1:0]     out_last;
        logic [OUT_SIZE_W-1:0] out_size;
        logic                  relu;
    } t_cfg;

    typedef struct packed {
        logic                  col_start;
        logic [OUT_AW-1:0]     start_col;
        logic                  issue;
        logic [IN_AW-1:0]      act_addr;
        logic                  bias_add;
        logic                  out_load;
        logic [OUT_AW-1:0]     out_col;
        logic                  last;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hdl/dlbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dlbr_ctrl
// Sequencer that walks the columns and input positions of one row and
// steers the datapath through multiply-accumulate, bias and output steps.
// ----------------------------------------------------------------------------
module dlbr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  dlbr_pkg::t_in_item i_data,
    input  dlbr_pkg::t_cfg     i_cfg,
    input  dlbr_pkg::t_dp_sts  i_sts,
    output logic               o_stall,
    output dlbr_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [dlbr_pkg::IN_AW-1:0]  r_k, n_k;
    logic [dlbr_pkg::OUT_AW-1:0] r_n, n_n;
    logic                        w_trigger;

    assign o_stall   = (r_state != S_IDLE);
    assign w_trigger = i_valid && !o_stall && (i_data.cmd == dlbr_pkg::CMD_ACT)
                       && (i_data.index == 14'(i_cfg.in_last));

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_n     = r_n;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_trigger) begin
                    n_state         = S_MAC;
                    n_k             = '0;
                    n_n             = '0;
                    o_cmd.col_start = 1'b1;
                end
            end
            S_MAC: begin
                o_cmd.issue    = 1'b1;
                o_cmd.act_addr = r_k;
                if (r_k == i_cfg.in_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_sts.busy) begin
                    o_cmd.bias_add = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_col  = r_n;
                    o_cmd.last     = (r_n == i_cfg.out_last);
                    if (r_n == i_cfg.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state         = S_MAC;
                        n_k             = '0;
                        n_n             = r_n + 1'b1;
                        o_cmd.col_start = 1'b1;
                        o_cmd.start_col = r_n + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_n     <= n_n;
        end
    end

endmodule

// ===== hdl/dlbr_dp.sv =====
// ----------------------------------------------------------------------------
// dlbr_dp
// Weight, bias and activation stores, the multiply-accumulate pipeline,
// the bias, ReLU, rounding and saturation step, and the output register.
// ----------------------------------------------------------------------------
module dlbr_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  dlbr_pkg::t_in_item  i_data,
    input  dlbr_pkg::t_cfg      i_cfg,
    input  dlbr_pkg::t_dp_cmd   i_cmd,
    input  logic                i_stall,
    output dlbr_pkg::t_dp_sts   o_sts,
    output logic                o_valid,
    output dlbr_pkg::t_out_item o_data
);

    localparam int ACC_W = dlbr_pkg::ACC_W;
    localparam logic signed [ACC_W-1:0] ACC_QMAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] ACC_QMIN = ACC_W'(-32768);
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1 << (dlbr_pkg::FRAC_W - 1));

    logic signed [dlbr_pkg::DATA_W-1:0] r_wmem [dlbr_pkg::W_DEPTH];
    logic signed [dlbr_pkg::DATA_W-1:0] r_bmem [dlbr_pkg::MAX_OUTPUTS];
    logic signed [dlbr_pkg::DATA_W-1:0] r_amem [dlbr_pkg::MAX_INPUTS];

    logic [dlbr_pkg::W_AW-1:0]          r_wa;
    logic signed [dlbr_pkg::DATA_W-1:0] r_w_q, r_a_q, r_bias_q;
    logic signed [dlbr_pkg::PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]            r_acc;
    logic                               r_p1, r_p2;
    logic                               r_out_valid;
    dlbr_pkg::t_out_item                r_out;

    logic signed [ACC_W-1:0]            w_relu, w_rnd, w_q;
    logic signed [dlbr_pkg::DATA_W-1:0] w_sat;
    logic                               w_out_free;

    always_ff @(posedge i_clk) begin
        if (i_wr && (i_data.cmd == dlbr_pkg::CMD_WEIGHT)
                && (32'(i_data.index) < 32'(dlbr_pkg::W_DEPTH))) begin
            r_wmem[i_data.index[dlbr_pkg::W_AW-1:0]] <= i_data.value;
        end
        if (i_wr && (i_data.cmd == dlbr_pkg::CMD_BIAS)
                && (32'(i_data.index) < 32'(dlbr_pkg::MAX_OUTPUTS))) begin
            r_bmem[i_data.index[dlbr_pkg::OUT_AW-1:0]] <= i_data.value;
        end
        if (i_wr && (i_data.cmd == dlbr_pkg::CMD_ACT)
                && (32'(i_data.index) < 32'(dlbr_pkg::MAX_INPUTS))) begin
            r_amem[i_data.index[dlbr_pkg::IN_AW-1:0]] <= i_data.value;
        end
        if (i_cmd.issue) begin
            r_w_q <= r_wmem[r_wa];
            r_a_q <= r_amem[i_cmd.act_addr];
        end
        if (i_cmd.col_start) begin
            r_bias_q <= r_bmem[i_cmd.start_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.col_start) begin
            r_wa <= dlbr_pkg::W_AW'(i_cmd.start_col);
        end else if (i_cmd.issue) begin
            r_wa <= r_wa + dlbr_pkg::W_AW'(i_cfg.out_size);
        end
        r_prod <= r_a_q * r_w_q;
        if (i_cmd.col_start) begin
            r_acc <= '0;
        end else if (i_cmd.bias_add) begin
            r_acc <= r_acc + (ACC_W'(r_bias_q) <<< dlbr_pkg::FRAC_W);
        end else if (r_p2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    always_comb begin
        w_relu = (i_cfg.relu && (r_acc < 0)) ? '0 : r_acc;
        w_rnd  = w_relu + ACC_HALF;
        w_q    = w_rnd >>> dlbr_pkg::FRAC_W;
        if (w_q > ACC_QMAX) begin
            w_sat = dlbr_pkg::DATA_W'(ACC_QMAX);
        end else if (w_q < ACC_QMIN) begin
            w_sat = dlbr_pkg::DATA_W'(ACC_QMIN);
        end else begin
            w_sat = w_q[dlbr_pkg::DATA_W-1:0];
        end
    end

    assign w_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.column       <= 6'(i_cmd.out_col);
            r_out.result_value <= w_sat;
            r_out.last         <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p1 <= i_cmd.issue;
            r_p2 <= r_p1;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.busy     = r_p1 || r_p2;
    assign o_sts.out_free = w_out_free;
    assign o_valid        = r_out_valid;
    assign o_data         = r_out;

endmodule

// ===== hdl/dense_layer_bias_relu.sv =====
// ----------------------------------------------------------------------------
// dense_layer_bias_relu
// Fully connected layer in Q8.8 with bias, optional ReLU and saturation.
// ----------------------------------------------------------------------------
// Weight, bias and activation beats are taken one per cycle while the input
// is not stalled. The activation beat at the last active position, in_size-1
// with in_size clamped to 1..256, starts the row computation, during which
// the input is stalled until the row's final result is loaded, which an
// output stall can delay. Each column runs the single multiply-accumulate
// unit fed by the one weight read port, pipeline drain, bias and output load.
module dense_layer_bias_relu (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  dlbr_pkg::t_in_item                   i_data,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output dlbr_pkg::t_out_item                  o_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dlbr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dlbr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [dlbr_pkg::IN_SIZE_W-1:0]  r_in_size, w_in_eff;
    logic [dlbr_pkg::OUT_SIZE_W-1:0] r_out_size, w_out_eff;
    logic                            r_relu_on;
    dlbr_pkg::t_cfg                  w_cfg;
    dlbr_pkg::t_dp_cmd               w_cmd;
    dlbr_pkg::t_dp_sts               w_sts;
    logic                            w_wr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_size  <= dlbr_pkg::IN_SIZE_W'(dlbr_pkg::MAX_INPUTS);
            r_out_size <= dlbr_pkg::OUT_SIZE_W'(dlbr_pkg::MAX_OUTPUTS);
            r_relu_on  <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                dlbr_pkg::CFG_IN_SIZE: begin
                    r_in_size <= i_cfg_data[dlbr_pkg::IN_SIZE_W-1:0];
                end
                dlbr_pkg::CFG_OUT_SIZE: begin
                    r_out_size <= i_cfg_data[dlbr_pkg::OUT_SIZE_W-1:0];
                end
                dlbr_pkg::CFG_RELU_ON: begin
                    r_relu_on <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_in_size == '0) begin
            w_in_eff = dlbr_pkg::IN_SIZE_W'(1);
        end else if (32'(r_in_size) > 32'(dlbr_pkg::MAX_INPUTS)) begin
            w_in_eff = dlbr_pkg::IN_SIZE_W'(dlbr_pkg::MAX_INPUTS);
        end else begin
            w_in_eff = r_in_size;
        end
        if (r_out_size == '0) begin
            w_out_eff = dlbr_pkg::OUT_SIZE_W'(1);
        end else if (32'(r_out_size) > 32'(dlbr_pkg::MAX_OUTPUTS)) begin
            w_out_eff = dlbr_pkg::OUT_SIZE_W'(dlbr_pkg::MAX_OUTPUTS);
        end else begin
            w_out_eff = r_out_size;
        end
        w_cfg.in_last  = dlbr_pkg::IN_AW'(w_in_eff - 1'b1);
        w_cfg.out_last = dlbr_pkg::OUT_AW'(w_out_eff - 1'b1);
        w_cfg.out_size = w_out_eff;
        w_cfg.relu     = r_relu_on;
    end

    assign w_wr = i_valid && !o_stall;

    dlbr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_cfg   (w_cfg),
        .i_sts   (w_sts),
        .o_stall (o_stall),
        .o_cmd   (w_cmd)
    );

    dlbr_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_data  (i_data),
        .i_cfg   (w_cfg),
        .i_cmd   (w_cmd),
        .i_stall (i_stall),
        .o_sts   (w_sts),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !w_sts.busy)
        else $error("Input taken while the MAC pipeline is busy.");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("Output register overwritten before its beat was taken.");

    a_bias_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.bias_add |-> (!w_sts.busy && !w_cmd.issue))
        else $error("Bias added while products are still in flight.");

    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.out_load && w_cmd.last) |=> !o_stall)
        else $error("Input still stalled after the final result of a row.");

endmodule

// ===== test/dense_layer_bias_relu_tb.sv =====
// ----------------------------------------------------------------------------
// dense_layer_bias_relu_tb
// Self-checking bench for the Q8.8 fully connected layer. Weight, bias and
// activation beats go in with random gaps, and each row result is compared
// with a dot product, bias, ReLU and saturation computed alongside. Directed
// beats cover rounding, saturation, ignored commands and register clamping.
// A long output hold-off follows, then random rows of changing layer sizes.
// ----------------------------------------------------------------------------
module dense_layer_bias_relu_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]                     CMD_SPARE     = 2'd3;
    localparam logic [dlbr_pkg::CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
    localparam int                             HOLD_CYCLES   = 400;
    localparam int                             SETTLE_CYCLES = 16;
    localparam int                             DRAIN_CYCLES  = 64;
    localparam int                             RANDOM_BEATS  = 75;
    localparam int                             TIMEOUT_NS    = 2_000_000;

    class neuron_scoreboard;
        localparam longint RES_MAX = 32767;
        localparam longint RES_MIN = -32768;

        logic signed [dlbr_pkg::DATA_W-1:0] weight_mem [dlbr_pkg::W_DEPTH];
        logic signed [dlbr_pkg::DATA_W-1:0] bias_mem [dlbr_pkg::MAX_OUTPUTS];
        logic signed [dlbr_pkg::DATA_W-1:0] act_mem [dlbr_pkg::MAX_INPUTS];
        logic [dlbr_pkg::IN_SIZE_W-1:0]     in_size;
        logic [dlbr_pkg::OUT_SIZE_W-1:0]    out_size;
        logic                               relu_on;
        dlbr_pkg::t_out_item                expected_outputs [$];
        int                                 mismatches;

        function new();
            in_size    = 9'd256;
            out_size   = 7'd64;
            relu_on    = 1'b1;
            mismatches = 0;
        endfunction

        function int active_inputs();
            if (in_size == 0) return 1;
            if (in_size > dlbr_pkg::MAX_INPUTS) return dlbr_pkg::MAX_INPUTS;
            return int'(in_size);
        endfunction

        function int active_outputs();
            if (out_size == 0) return 1;
            if (out_size > dlbr_pkg::MAX_OUTPUTS) return dlbr_pkg::MAX_OUTPUTS;
            return int'(out_size);
        endfunction

        function int outstanding();
            return expected_outputs.size();
        endfunction

        function void take_config(logic [dlbr_pkg::CFG_IDX_W-1:0] idx,
                                  logic [dlbr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                dlbr_pkg::CFG_IN_SIZE:  in_size  = data[dlbr_pkg::IN_SIZE_W-1:0];
                dlbr_pkg::CFG_OUT_SIZE: out_size = data[dlbr_pkg::OUT_SIZE_W-1:0];
                dlbr_pkg::CFG_RELU_ON:  relu_on  = data[0];
                default: ;
            endcase
        endfunction

        function void compute_row();
            int                  ni;
            int                  no;
            longint              acc;
            longint              rounded;
            dlbr_pkg::t_out_item item;
            ni = active_inputs();
            no = active_outputs();
            for (int n = 0; n < no; n++) begin
                acc = longint'(bias_mem[n]) * 256;
                for (int k = 0; k < ni; k++) begin
                    acc += longint'(act_mem[k]) * longint'(weight_mem[k * no + n]);
                end
                if (relu_on && acc < 0) begin
                    acc = 0;
                end
                rounded = (acc + 128) >>> 8;
                if (rounded > RES_MAX) begin
                    rounded = RES_MAX;
                end else if (rounded < RES_MIN) begin
                    rounded = RES_MIN;
                end
                item.column       = 6'(n);
                item.result_value = 16'(rounded);
                item.last         = (n == no - 1);
                expected_outputs.push_back(item);
            end
        endfunction

        function void take_input(dlbr_pkg::t_in_item beat);
            case (beat.cmd)
                dlbr_pkg::CMD_WEIGHT: begin
                    weight_mem[beat.index] = beat.value;
                end
                dlbr_pkg::CMD_BIAS: begin
                    if (beat.index < dlbr_pkg::MAX_OUTPUTS) bias_mem[beat.index] = beat.value;
                end
                dlbr_pkg::CMD_ACT: begin
                    if (beat.index < dlbr_pkg::MAX_INPUTS) begin
                        act_mem[beat.index] = beat.value;
                        if (beat.index == active_inputs() - 1) compute_row();
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_output(dlbr_pkg::t_out_item got);
            dlbr_pkg::t_out_item want;
            if (expected_outputs.size() == 0) begin
                $error("unexpected result beat: column %0d result_value %0d last %0d",
                       got.column, got.result_value, got.last);
                mismatches++;
                return;
            end
            want = expected_outputs.pop_front();
            if (got.column !== want.column) begin
                $error("column: expected %0d, actual %0d", want.column, got.column);
                mismatches++;
            end
            if (got.result_value !== want.result_value) begin
                $error("result_value: expected %0d, actual %0d",
                       want.result_value, got.result_value);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_stall;
    dlbr_pkg::t_in_item              i_data;
    logic                            o_valid;
    logic                            i_stall;
    dlbr_pkg::t_out_item             o_data;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [dlbr_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [dlbr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    neuron_scoreboard layer_check = new();

    bit weight_loaded [dlbr_pkg::W_DEPTH];
    bit bias_loaded [dlbr_pkg::MAX_OUTPUTS];
    bit act_loaded [dlbr_pkg::MAX_INPUTS];
    bit steady = 1'b0;
    bit hold_request = 1'b0;
    int useful_beats = 0;

    dense_layer_bias_relu dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            layer_check.check_output(o_data);
        end
    end

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3: return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_beat(dlbr_pkg::t_in_item beat);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        do @(posedge i_clk); while (o_stall);
        layer_check.take_input(beat);
    endtask

    task automatic send_item(logic [1:0] cmd, int idx, logic [15:0] value);
        dlbr_pkg::t_in_item beat;
        beat.cmd   = cmd;
        beat.index = idx[13:0];
        beat.value = value;
        case (cmd)
            dlbr_pkg::CMD_WEIGHT: begin
                weight_loaded[idx] = 1'b1;
                useful_beats++;
            end
            dlbr_pkg::CMD_BIAS: begin
                if (idx < dlbr_pkg::MAX_OUTPUTS) begin
                    bias_loaded[idx] = 1'b1;
                    useful_beats++;
                end
            end
            dlbr_pkg::CMD_ACT: begin
                if (idx < dlbr_pkg::MAX_INPUTS) begin
                    act_loaded[idx] = 1'b1;
                    useful_beats++;
                end
            end
            default: ;
        endcase
        send_beat(beat);
    endtask

    task automatic send_noise();
        int ni;
        ni = layer_check.active_inputs();
        case ($urandom_range(0, 5))
            0: send_item(CMD_SPARE, $urandom_range(0, 16383), 16'($urandom));
            1: send_item(dlbr_pkg::CMD_BIAS, $urandom_range(dlbr_pkg::MAX_OUTPUTS, 16383),
                         pick_value());
            2: send_item(dlbr_pkg::CMD_ACT, $urandom_range(dlbr_pkg::MAX_INPUTS, 16383),
                         pick_value());
            3: begin
                if (ni < dlbr_pkg::MAX_INPUTS) begin
                    send_item(dlbr_pkg::CMD_ACT, $urandom_range(ni, dlbr_pkg::MAX_INPUTS - 1),
                              pick_value());
                end else begin
                    send_item(CMD_SPARE, $urandom_range(0, 16383), 16'($urandom));
                end
            end
            4: send_item(dlbr_pkg::CMD_WEIGHT, $urandom_range(0, dlbr_pkg::W_DEPTH - 1),
                         pick_value());
            default: send_item(dlbr_pkg::CMD_BIAS, $urandom_range(0, dlbr_pkg::MAX_OUTPUTS - 1),
                               pick_value());
        endcase
    endtask

    task automatic send_row();
        int ni;
        int no;
        int addr;
        ni = layer_check.active_inputs();
        no = layer_check.active_outputs();
        for (int n = 0; n < no; n++) begin
            if (!bias_loaded[n]) send_item(dlbr_pkg::CMD_BIAS, n, pick_value());
        end
        for (int k = 0; k < ni; k++) begin
            for (int n = 0; n < no; n++) begin
                addr = k * no + n;
                if (!weight_loaded[addr]) send_item(dlbr_pkg::CMD_WEIGHT, addr, pick_value());
            end
        end
        for (int k = 0; k < ni; k++) begin
            if ($urandom_range(0, 7) == 0) send_noise();
            if (k == ni - 1 || !act_loaded[k] || $urandom_range(0, 3) != 0) begin
                send_item(dlbr_pkg::CMD_ACT, k, pick_value());
            end
        end
    endtask

    task automatic drain_results(int cycles);
        i_valid <= 1'b0;
        while (layer_check.outstanding() != 0) @(posedge i_clk);
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [dlbr_pkg::CFG_IDX_W-1:0] idx,
                             logic [dlbr_pkg::CFG_DATA_W-1:0] data, bit final_write);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        layer_check.take_config(idx, data);
        if (final_write) i_cfg_valid <= 1'b0;
    endtask

    task automatic set_layer(logic [8:0] in_count, logic [6:0] out_count, logic relu);
        drain_results(SETTLE_CYCLES);
        write_reg(dlbr_pkg::CFG_IN_SIZE, in_count, 1'b0);
        write_reg(dlbr_pkg::CFG_OUT_SIZE, {2'($urandom), out_count}, 1'b0);
        write_reg(dlbr_pkg::CFG_RELU_ON, {8'($urandom), relu}, 1'b1);
    endtask

    initial begin : result_sink
        int gap;
        i_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin : stimulus
        int target;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With the reset sizes only position 255 starts a row.
        send_item(dlbr_pkg::CMD_WEIGHT, dlbr_pkg::W_DEPTH - 1, 16'h8000);
        send_item(dlbr_pkg::CMD_BIAS, dlbr_pkg::MAX_OUTPUTS - 1, 16'h7FFF);
        send_item(dlbr_pkg::CMD_ACT, 0, 16'h7FFF);
        send_item(CMD_SPARE, 16383, 16'hFFFF);
        send_item(dlbr_pkg::CMD_BIAS, dlbr_pkg::MAX_OUTPUTS, 16'h1234);
        send_item(dlbr_pkg::CMD_ACT, dlbr_pkg::MAX_INPUTS, 16'h1234);
        send_item(dlbr_pkg::CMD_ACT, 16383, 16'h5555);

        drain_results(SETTLE_CYCLES);
        write_reg(dlbr_pkg::CFG_IN_SIZE, 9'd1, 1'b0);
        write_reg(dlbr_pkg::CFG_OUT_SIZE, 9'd1, 1'b1);
        send_item(dlbr_pkg::CMD_WEIGHT, 0, 16'h7FFF);
        send_item(dlbr_pkg::CMD_BIAS, 0, 16'h7FFF);
        send_item(dlbr_pkg::CMD_ACT, 5, 16'h0100);
        send_item(dlbr_pkg::CMD_ACT, 0, 16'h7FFF);
        send_item(dlbr_pkg::CMD_ACT, 0, 16'h8000);
        drain_results(SETTLE_CYCLES);
        write_reg(dlbr_pkg::CFG_RELU_ON, 9'd0, 1'b1);
        send_item(dlbr_pkg::CMD_ACT, 0, 16'h8000);
        send_item(dlbr_pkg::CMD_WEIGHT, 0, 16'h8000);
        send_item(dlbr_pkg::CMD_ACT, 0, 16'h8000);
        send_item(dlbr_pkg::CMD_WEIGHT, 0, 16'h0080);
        send_item(dlbr_pkg::CMD_BIAS, 0, 16'h0000);
        send_item(dlbr_pkg::CMD_ACT, 0, 16'h0001);
        send_item(dlbr_pkg::CMD_ACT, 0, 16'hFFFF);
        send_item(dlbr_pkg::CMD_ACT, 0, 16'h0003);
        send_item(dlbr_pkg::CMD_ACT, 0, 16'hFFFD);
        send_item(dlbr_pkg::CMD_BIAS, 0, 16'h8000);
        send_item(dlbr_pkg::CMD_ACT, 0, 16'h0000);
        drain_results(SETTLE_CYCLES);
        write_reg(CFG_SPARE, 9'h1FF, 1'b1);
        send_item(dlbr_pkg::CMD_ACT, 0, 16'h0100);

        set_layer(9'd0, 7'd0, 1'b1);
        send_row();

        // Results back up behind a long hold-off until the input stalls.
        set_layer(9'd6, 7'd8, 1'b0);
        hold_request = 1'b1;
        repeat (3) send_row();

        target = useful_beats + RANDOM_BEATS;
        while (useful_beats < target) begin
            if ($urandom_range(0, 9) == 0) begin
                set_layer(9'($urandom_range(9, 16)), 7'($urandom_range(1, 4)), 1'($urandom));
            end else begin
                set_layer(9'($urandom_range(1, 8)), 7'($urandom_range(1, 8)), 1'($urandom));
            end
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(0, 2)) send_noise();
                send_row();
            end
        end
        steady = 1'b0;

        drain_results(DRAIN_CYCLES);
        if (layer_check.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dlbr_pkg.sv
hdl/dlbr_ctrl.sv
hdl/dlbr_dp.sv
hdl/dense_layer_bias_relu.sv
test/dense_layer_bias_relu_tb.sv
